/* rtl/core/rus_pkg.sv */
// ----------------------------------------------------------------------------
// rus_pkg
// Shared widths, register indexes, reset values and types for the ultrasonic
// range sequencer.
// ----------------------------------------------------------------------------
package rus_pkg;

    localparam int TIME_BITS = 32;
    localparam int ECHO_BITS = 16;
    localparam int DIST_BITS = 10;
    localparam int QUOT_BITS = 11;           // floor((10*65535+294)/588) = 1115

    localparam int PERIOD_BITS  = 16;
    localparam int TIMEOUT_BITS = 8;
    localparam int MAXECHO_BITS = 16;
    localparam int MAXDIST_BITS = 9;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAXECHO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAXDIST = 2'd3;

    localparam logic [PERIOD_BITS-1:0]  RST_PERIOD  = 16'd60;
    localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT = 8'd30;
    localparam logic [MAXECHO_BITS-1:0] RST_MAXECHO = 16'd30000;
    localparam logic [MAXDIST_BITS-1:0] RST_MAXDIST = 9'd400;

    // distance = (10*us + 294) / 588, done as multiply by 2^30/588 rounded up.
    // Exact for numerators below 2^20 since 272 * 2^20 < 2^30.
    localparam int NUM_BITS    = 20;
    localparam int RECIP_BITS  = 21;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_BITS-1:0] RECIP_MUL  = 21'd1826092;
    localparam logic [NUM_BITS-1:0]   ROUND_BIAS = 20'd294;

    localparam logic signed [DIST_BITS-1:0] DIST_INVALID = -10'sd1;

    typedef struct packed {
        logic [PERIOD_BITS-1:0]  trig_period;
        logic [TIMEOUT_BITS-1:0] timeout_ms;
        logic [MAXECHO_BITS-1:0] max_echo_us;
        logic [MAXDIST_BITS-1:0] max_dist_cm;
    } t_cfg;

endpackage

/* rtl/core/rus_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rus_cfg_regs
// Configuration register file, write only, masked to each register width.
// ----------------------------------------------------------------------------
module rus_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rus_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [rus_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output rus_pkg::t_cfg                     o_cfg
);
    import rus_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_period <= RST_PERIOD;
            r_cfg.timeout_ms  <= RST_TIMEOUT;
            r_cfg.max_echo_us <= RST_MAXECHO;
            r_cfg.max_dist_cm <= RST_MAXDIST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PERIOD:  r_cfg.trig_period <= i_cfg_data[PERIOD_BITS-1:0];
                REG_TIMEOUT: r_cfg.timeout_ms  <= i_cfg_data[TIMEOUT_BITS-1:0];
                REG_MAXECHO: r_cfg.max_echo_us <= i_cfg_data[MAXECHO_BITS-1:0];
                REG_MAXDIST: r_cfg.max_dist_cm <= i_cfg_data[MAXDIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/rus_core.sv */
// ----------------------------------------------------------------------------
// rus_core
// Ranging state: ms timer, trigger scheduling, echo capture and distance
// evaluation. One item is applied per enabled cycle.
// ----------------------------------------------------------------------------
module rus_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_req_type,
    input  logic [rus_pkg::ECHO_BITS-1:0]        i_echo_us,
    input  rus_pkg::t_cfg                        i_cfg,
    output logic                                 o_fire,
    output logic signed [rus_pkg::DIST_BITS-1:0] o_dist
);
    import rus_pkg::*;

    logic [TIME_BITS-1:0]        r_ms_cnt;
    logic [TIME_BITS-1:0]        r_trig_ms;     // last trigger time
    logic                        r_awaiting;
    logic                        r_pending;
    logic [ECHO_BITS-1:0]        r_echo_width;
    logic [QUOT_BITS-1:0]        r_echo_quot;   // width already scaled to cm
    logic signed [DIST_BITS-1:0] r_dist;

    logic [TIME_BITS-1:0]            n_ms_cnt;
    logic [TIME_BITS-1:0]            elapsed;
    logic                            fire;
    logic                            timed_out;
    logic                            echo_bad;
    logic [NUM_BITS-1:0]             num;
    logic [NUM_BITS+RECIP_BITS-1:0]  prod;
    logic signed [DIST_BITS-1:0]     eval_dist;
    logic signed [DIST_BITS-1:0]     n_dist;

    assign n_ms_cnt  = r_ms_cnt + TIME_BITS'(1);
    assign elapsed   = n_ms_cnt - r_trig_ms;
    assign fire      = !i_req_type && (elapsed >= TIME_BITS'(i_cfg.trig_period));
    assign timed_out = r_awaiting && (elapsed > TIME_BITS'(i_cfg.timeout_ms));

    // 10*us + 294 as shift-add, then reciprocal multiply
    assign num  = (NUM_BITS'(i_echo_us) << 3) + (NUM_BITS'(i_echo_us) << 1) + ROUND_BIAS;
    assign prod = (NUM_BITS+RECIP_BITS)'(num) * (NUM_BITS+RECIP_BITS)'(RECIP_MUL);

    assign echo_bad = (r_echo_width == '0)
                   || (r_echo_width > i_cfg.max_echo_us)
                   || (r_echo_quot > QUOT_BITS'(i_cfg.max_dist_cm));
    assign eval_dist = echo_bad ? DIST_INVALID : DIST_BITS'(r_echo_quot);

    always_comb begin
        n_dist = r_dist;
        if (!i_req_type && !fire) begin
            if (r_pending) begin
                n_dist = eval_dist;
            end else if (timed_out) begin
                n_dist = DIST_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_cnt   <= '0;
            r_trig_ms  <= '0;
            r_awaiting <= 1'b0;
            r_pending  <= 1'b0;
            r_dist     <= DIST_INVALID;
        end else if (i_en) begin
            r_dist <= n_dist;
            if (!i_req_type) begin
                r_ms_cnt <= n_ms_cnt;
                if (fire) begin
                    r_trig_ms  <= n_ms_cnt;
                    r_pending  <= 1'b0;
                    r_awaiting <= 1'b1;
                end else if (r_pending) begin
                    r_pending <= 1'b0;
                end else if (timed_out) begin
                    r_awaiting <= 1'b0;
                end
            end else begin
                r_pending  <= 1'b1;
                r_awaiting <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_req_type) begin
            r_echo_width <= i_echo_us;
            r_echo_quot  <= prod[RECIP_SHIFT +: QUOT_BITS];
        end
    end

    assign o_fire = fire;
    assign o_dist = n_dist;

endmodule

/* rtl/core/rus_out_stage.sv */
// ----------------------------------------------------------------------------
// rus_out_stage
// Result register on the master side; loads whenever empty or being drained.
// ----------------------------------------------------------------------------
module rus_out_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic                                 i_fire,
    input  logic signed [rus_pkg::DIST_BITS-1:0] i_dist,
    input  logic                                 i_ready,
    output logic                                 o_space,
    output logic                                 o_valid,
    output logic                                 o_fire,
    output logic signed [rus_pkg::DIST_BITS-1:0] o_dist
);
    import rus_pkg::*;

    logic                        r_valid;
    logic                        r_fire;
    logic signed [DIST_BITS-1:0] r_dist;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fire <= i_fire;
            r_dist <= i_dist;
        end
    end

    assign o_valid = r_valid;
    assign o_fire  = r_fire;
    assign o_dist  = r_dist;

endmodule

/* rtl/core/ultrasonic_range_sequencer_top.sv */
// Ultrasonic range sequencer. Items arrive on the slave stream: tuser 0 is a
// one millisecond tick, tuser 1 carries a captured echo width in us on tdata.
// Every item gives exactly one result: tuser is the trigger request (ask the
// pin logic for a 12 us pulse), tdata the latest distance in cm, -1 when the
// echo was empty, too long, out of range or missed. A new distance shows on
// the tick after the echo unless that tick fires, which drops it. One item
// per clock unless stalled, via an input register, then a result register
// freed as it drains (input and output overlap). Configuration is written
// via a plain write port, by users only while no item is in flight; unchecked.
// ----------------------------------------------------------------------------
// ultrasonic_range_sequencer_top
// Input register, ranging core, result register and configuration registers.
// ----------------------------------------------------------------------------
module ultrasonic_range_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [15:0] echo_us
    input  logic [0:0]                        s_axis_tuser,  // [0] req_type
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // [9:0] distance_cm, zero pad
    output logic [0:0]                        m_axis_tuser,  // [0] trigger_fire
    input  logic                              i_cfg_we,
    input  logic [rus_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [rus_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import rus_pkg::*;

    t_cfg cfg;

    logic                 r_in_valid;
    logic                 r_in_type;
    logic [ECHO_BITS-1:0] r_in_echo;

    logic                        adv;
    logic                        out_space;
    logic                        core_fire;
    logic signed [DIST_BITS-1:0] core_dist;
    logic signed [DIST_BITS-1:0] out_dist;

    rus_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign adv           = r_in_valid && out_space;
    assign s_axis_tready = !r_in_valid || out_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_type <= s_axis_tuser[0];
            r_in_echo <= s_axis_tdata;
        end
    end

    rus_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_req_type (r_in_type),
        .i_echo_us  (r_in_echo),
        .i_cfg      (cfg),
        .o_fire     (core_fire),
        .o_dist     (core_dist)
    );

    rus_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_fire  (core_fire),
        .i_dist  (core_dist),
        .i_ready (m_axis_tready),
        .o_space (out_space),
        .o_valid (m_axis_tvalid),
        .o_fire  (m_axis_tuser[0]),
        .o_dist  (out_dist)
    );

    assign m_axis_tdata = {6'd0, out_dist};

    // echo items never request a trigger
    a_no_fire_on_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_type) |-> !core_fire)
        else $error("trigger requested on echo item");

    // distance is either a valid 9-bit value or -1
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[9] || m_axis_tdata[9:0] == 10'h3FF))
        else $error("distance out of range");

    // an empty result register never blocks the input side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // an advanced item always produces a result next cycle
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> m_axis_tvalid)
        else $error("result lost");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ultrasonic_range_sequencer_top. Tick and echo words
// are streamed in with random gaps and output back-pressure. A scoreboard
// tracks the millisecond counter, the trigger and timeout state and the
// configuration, and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rus_pkg::*;

    typedef enum logic {REQ_TICK = 1'b0, REQ_ECHO = 1'b1} t_req_kind;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;

    class range_scoreboard;
        typedef struct packed {
            logic                        fire;
            logic signed [DIST_BITS-1:0] cm;
        } t_range_word;

        t_range_word expected_ranges[$];
        int          mismatches;

        logic [PERIOD_BITS-1:0]      period;
        logic [TIMEOUT_BITS-1:0]     timeout;
        logic [MAXECHO_BITS-1:0]     max_echo;
        logic [MAXDIST_BITS-1:0]     max_dist;

        logic [TIME_BITS-1:0]        ms_count;
        logic [TIME_BITS-1:0]        last_trig_ms;
        logic [TIME_BITS-1:0]        trig_ms;
        logic                        awaiting;
        logic [ECHO_BITS-1:0]        echo_w;
        logic                        pending;
        logic signed [DIST_BITS-1:0] last_cm;

        function new();
            period       = RST_PERIOD;
            timeout      = RST_TIMEOUT;
            max_echo     = RST_MAXECHO;
            max_dist     = RST_MAXDIST;
            ms_count     = '0;
            last_trig_ms = '0;
            trig_ms      = '0;
            awaiting     = 1'b0;
            echo_w       = '0;
            pending      = 1'b0;
            last_cm      = DIST_INVALID;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_PERIOD:  period   = data[PERIOD_BITS-1:0];
                REG_TIMEOUT: timeout  = data[TIMEOUT_BITS-1:0];
                REG_MAXECHO: max_echo = data[MAXECHO_BITS-1:0];
                REG_MAXDIST: max_dist = data[MAXDIST_BITS-1:0];
                default: ;
            endcase
        endfunction

        // round(us / 58.8) with half-up rounding, then range limits
        function logic signed [DIST_BITS-1:0] echo_to_cm(logic [ECHO_BITS-1:0] us);
            logic [31:0] q;
            if (us == '0 || us > max_echo)
                return DIST_INVALID;
            q = (32'd10 * 32'(us) + 32'd294) / 32'd588;
            if (q > 32'(max_dist))
                return DIST_INVALID;
            return q[DIST_BITS-1:0];
        endfunction

        function void note_item(t_req_kind kind, logic [ECHO_BITS-1:0] us);
            t_range_word w;
            logic [TIME_BITS-1:0] since;
            w.fire = 1'b0;
            if (kind == REQ_TICK) begin
                ms_count = ms_count + TIME_BITS'(1);
                since = ms_count - last_trig_ms;
                if (since >= TIME_BITS'(period)) begin
                    last_trig_ms = ms_count;
                    trig_ms      = ms_count;
                    pending      = 1'b0;
                    awaiting     = 1'b1;
                    w.fire       = 1'b1;
                end
                since = ms_count - trig_ms;
                if (pending) begin
                    pending = 1'b0;
                    last_cm = echo_to_cm(echo_w);
                end else if (awaiting && since > TIME_BITS'(timeout)) begin
                    last_cm  = DIST_INVALID;
                    awaiting = 1'b0;
                end
            end else begin
                echo_w   = us;
                pending  = 1'b1;
                awaiting = 1'b0;
            end
            w.cm = last_cm;
            expected_ranges.push_back(w);
        endfunction

        function void check_result(logic fire, logic [15:0] data);
            t_range_word w;
            if (expected_ranges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: fire %0d distance %0d",
                             fire, $signed(data[DIST_BITS-1:0]));
                return;
            end
            w = expected_ranges.pop_front();
            if (fire !== w.fire || data[DIST_BITS-1:0] !== w.cm) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: fire exp %0d got %0d, distance exp %0d got %0d",
                             w.fire, fire, w.cm, $signed(data[DIST_BITS-1:0]));
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [15:0]              s_tdata = '0;
    logic [0:0]               s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [15:0]              m_tdata;
    logic [0:0]               m_tuser;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    bit              idle_on = 1'b1;
    int              quiet_cycles = 0;
    range_scoreboard ranges = new();

    ultrasonic_range_sequencer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            ranges.check_result(m_tuser[0], m_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // leaves tvalid high after the accepting edge; the next call or drain decides
    task automatic send_word(t_req_kind kind, logic [15:0] us);
        while (idle_on && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= us;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        ranges.note_item(kind, us);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ranges.expected_ranges.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // caller lowers i_cfg_we after the last write of a group
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        ranges.set_reg(idx, data);
    endtask

    task automatic write_all(logic [15:0] per, logic [15:0] tmo, logic [15:0] mxe,
                             logic [15:0] mxd);
        write_reg(REG_PERIOD, per);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_MAXECHO, mxe);
        write_reg(REG_MAXDIST, mxd);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure_phase(int phase);
        logic [15:0] per, tmo, mxe, mxd;
        case (phase)
            0: begin
                per = 16'd1;
                tmo = {8'($urandom), 8'd1};
                mxe = 16'd1;
                mxd = {7'($urandom), 9'd1};
            end
            1: begin
                per = 16'hFFFF;
                tmo = 16'h00FF;
                mxe = 16'hFFFF;
                mxd = 16'h01FF;
            end
            default: begin
                per = 16'($urandom_range(1, 25));
                tmo = {8'($urandom), 8'($urandom_range(0, 20))};
                mxe = 16'($urandom_range(1000, 65535));
                mxd = {7'($urandom), 9'($urandom_range(1, 511))};
            end
        endcase
        write_all(per, tmo, mxe, mxd);
    endtask

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return ranges.max_echo;
            2:       return ranges.max_echo + 16'd1;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(1, 24000));
        endcase
    endfunction

    // mostly tick runs closed by an echo and its evaluating tick, some noise
    task automatic random_phase();
        int done, n;
        done = 0;
        while (done < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                n = $urandom_range(0, 12);
                repeat (n) send_word(REQ_TICK, 16'($urandom));
                send_word(REQ_ECHO, pick_width());
                done += n + 2;
                if ($urandom_range(0, 4) == 0) begin
                    send_word(REQ_ECHO, pick_width());
                    done++;
                end
                send_word(REQ_TICK, 16'($urandom));
            end else begin
                send_word(t_req_kind'($urandom_range(0, 1)), 16'($urandom));
                done++;
            end
        end
    endtask

    task automatic directed();
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_TICK, 16'hFFFF);
        send_word(REQ_ECHO, 16'd0);       // empty echo
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_ECHO, 16'd1);       // shortest echo rounds to zero
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_ECHO, 16'hFFFF);    // beyond echo limit
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_ECHO, 16'd30000);   // at echo limit, beyond range
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_ECHO, 16'd23520);   // exactly at range limit
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_ECHO, 16'd23550);   // one cm past range limit
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_ECHO, 16'd5000);    // only the later echo counts
        send_word(REQ_ECHO, 16'd1000);
        send_word(REQ_TICK, 16'd0);
        drain();
        // zero period: trigger on each tick, dropping the pending echo
        write_all(16'd0, 16'd0, 16'hFFFF, 16'h01FF);
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_ECHO, 16'd200);
        send_word(REQ_TICK, 16'd0);
        drain();
        // zero timeout: first elapsed ms after a trigger gives invalid
        write_all(16'd2, 16'd0, 16'hFFFF, 16'h01FF);
        send_word(REQ_ECHO, 16'd300);
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_TICK, 16'd0);
        send_word(REQ_TICK, 16'd0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            configure_phase(phase);
            idle_on = (phase != 2);
            random_phase();
        end
        drain();
        if (ranges.mismatches == 0 && ranges.expected_ranges.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rus_pkg.sv
rtl/core/rus_cfg_regs.sv
rtl/core/rus_core.sv
rtl/core/rus_out_stage.sv
rtl/core/ultrasonic_range_sequencer_top.sv
tb/testbench.sv
